// ===== rtl/fpr_pkg.sv =====
// Shared types and codes for the FIFO with prefix reverse.
// Used by the ring memory and the top level; depends on nothing.
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int CNT_W = 7;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_REV = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADK  = 2'd3;

  localparam logic signed [VAL_W-1:0] POP_NONE  = 32'sd0;
  localparam logic signed [VAL_W-1:0] POP_EMPTY = -32'sd1;

  typedef struct packed {
    logic we;
    logic rd_a_en;
    logic rd_b_en;
  } mem_ctl_t;

endpackage

// ===== rtl/fpr_ring_mem.sv =====
// Ring storage: one write port and two read ports with registered read data.
// Depends on fpr_pkg for the control struct.
`timescale 1ns / 1ps

module fpr_ring_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  fpr_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DW-1:0]            rdata_a,
  output logic [DW-1:0]            rdata_b
);
  import fpr_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a_r;
  logic [DW-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_a_en) begin
      rdata_a_r <= mem[raddr_a];
    end
    if (ctl.rd_b_en) begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/fpr_wrap_add.sv =====
// Shared modular index adder: (idx + off) mod DEPTH for idx, off < DEPTH.
// Standalone; one compare and subtract after the add.
`timescale 1ns / 1ps

module fpr_wrap_add #(
  parameter int DEPTH = 64
) (
  input  logic [$clog2(DEPTH)-1:0] idx,
  input  logic [$clog2(DEPTH)-1:0] off,
  output logic [$clog2(DEPTH)-1:0] sum
);
  localparam int AW = $clog2(DEPTH);

  logic [AW:0] raw;
  logic [AW:0] wrapped;

  always_comb begin
    raw     = {1'b0, idx} + {1'b0, off};
    wrapped = (raw >= (AW + 1)'(DEPTH)) ? raw - (AW + 1)'(DEPTH) : raw;
    sum     = wrapped[AW-1:0];
  end

endmodule

// ===== rtl/fifo_with_prefix_reverse_unit.sv =====
// Bounded FIFO of signed words with a reverse-first-k operation.
// Depends on fpr_pkg, fpr_ring_mem and fpr_wrap_add.
//
// Usage: drive in_operation, in_push_value and in_reverse_count with start
// high; the beat is taken at a rising edge where busy is low. Each beat
// yields exactly one result beat, shown on out_pop_value, out_status and
// out_entry_count for one cycle with out_valid high. The receiver cannot
// hold results off; each result is presented once.
// Throughput: an enqueue, a rejected operation, a reverse of a single
// entry and the unused code never raise busy, so they can be issued every
// cycle. A dequeue reads the ring and raises busy while the read completes.
// A valid reverse of k entries walks the ring from both ends, floor(k/2)
// swaps in all; each swap reads both entries, writes one, then writes the
// other (S_SW_RD, S_SW_WA, S_SW_WB) on the single write port.
// Every index step goes through one shared modular adder.
// Reset clears head, tail and the count; the ring contents are not cleared
// and only held entries are ever read.
`timescale 1ns / 1ps

module fifo_with_prefix_reverse_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [fpr_pkg::OP_W-1:0]          in_operation,
  input  logic signed [fpr_pkg::VAL_W-1:0]  in_push_value,
  input  logic [fpr_pkg::CNT_W-1:0]         in_reverse_count,
  output logic                              out_valid,
  output logic signed [fpr_pkg::VAL_W-1:0]  out_pop_value,
  output logic [fpr_pkg::ST_W-1:0]          out_status,
  output logic [fpr_pkg::CNT_W-1:0]         out_entry_count
);
  import fpr_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;
  localparam int EXW  = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
  localparam int PW   = CNT_W - 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEQ    = 3'd1;
  localparam logic [2:0] S_SW_RD  = 3'd2;
  localparam logic [2:0] S_SW_WA  = 3'd3;
  localparam logic [2:0] S_SW_WB  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [AW-1:0] b_r, b_nxt;
  logic [PW-1:0] pairs_r, pairs_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_pop_r, out_pop_nxt;
  logic [ST_W-1:0]         out_status_r, out_status_nxt;

  logic [AW-1:0] wa_idx;
  logic [AW-1:0] wa_off;
  logic [AW-1:0] wa_sum;

  mem_ctl_t              mem_ctl;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr_a;
  logic [DATA_WIDTH-1:0] rdata_a;
  logic [DATA_WIDTH-1:0] rdata_b;

  logic                         accept;
  logic [CMPW-1:0]              k_ext;
  logic [CMPW-1:0]              cnt_ext;
  logic [CMPW-1:0]              k_m1;
  logic                         k_bad;
  logic signed [EXW-1:0]        push_ext;
  logic signed [DATA_WIDTH-1:0] rd_a_s;
  logic signed [EXW-1:0]        pop_ext;

  fpr_wrap_add #(.DEPTH(DEPTH)) u_wrap (
    .idx (wa_idx),
    .off (wa_off),
    .sum (wa_sum)
  );

  fpr_ring_mem #(.DEPTH(DEPTH), .DW(DATA_WIDTH)) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (b_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign accept   = start && (state_r == S_IDLE);
  assign k_ext    = CMPW'(in_reverse_count);
  assign cnt_ext  = CMPW'(count_r);
  assign k_m1     = k_ext - CMPW'(1);
  assign k_bad    = (k_ext == '0) || (k_ext > cnt_ext);
  assign push_ext = EXW'(in_push_value);
  assign rd_a_s   = rdata_a;
  assign pop_ext  = EXW'(rd_a_s);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    pairs_nxt      = pairs_r;
    out_valid_nxt  = 1'b0;
    out_pop_nxt    = POP_NONE;
    out_status_nxt = ST_OK;
    wa_idx         = tail_r;
    wa_off         = AW'(1);
    mem_ctl        = '0;
    mem_waddr      = tail_r;
    mem_wdata      = push_ext[DATA_WIDTH-1:0];
    mem_raddr_a    = a_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_ENQ: begin
              out_valid_nxt = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                mem_ctl.we = 1'b1;
                tail_nxt   = wa_sum;
                count_nxt  = count_r + CW'(1);
              end
            end
            OP_DEQ: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_pop_nxt    = POP_EMPTY;
                out_status_nxt = ST_EMPTY;
              end else begin
                wa_idx          = head_r;
                mem_raddr_a     = head_r;
                mem_ctl.rd_a_en = 1'b1;
                head_nxt        = wa_sum;
                count_nxt       = count_r - CW'(1);
                state_nxt       = S_DEQ;
              end
            end
            OP_REV: begin
              if (k_bad) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BADK;
              end else if (in_reverse_count[CNT_W-1:1] == '0) begin
                // A single entry reversed is the queue as it was.
                out_valid_nxt = 1'b1;
              end else begin
                wa_idx    = head_r;
                wa_off    = k_m1[AW-1:0];
                a_nxt     = head_r;
                b_nxt     = wa_sum;
                pairs_nxt = in_reverse_count[CNT_W-1:1];
                state_nxt = S_SW_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        out_valid_nxt = 1'b1;
        out_pop_nxt   = pop_ext[VAL_W-1:0];
        state_nxt     = S_IDLE;
      end
      S_SW_RD: begin
        mem_ctl.rd_a_en = 1'b1;
        mem_ctl.rd_b_en = 1'b1;
        state_nxt       = S_SW_WA;
      end
      S_SW_WA: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = a_r;
        mem_wdata  = rdata_b;
        wa_idx     = a_r;
        a_nxt      = wa_sum;
        state_nxt  = S_SW_WB;
      end
      S_SW_WB: begin
        mem_ctl.we = 1'b1;
        mem_waddr  = b_r;
        mem_wdata  = rdata_a;
        // Stepping down by one is stepping up by DEPTH-1 around the ring.
        wa_idx     = b_r;
        wa_off     = AW'(DEPTH - 1);
        b_nxt      = wa_sum;
        pairs_nxt  = pairs_r - PW'(1);
        if (pairs_r == PW'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SW_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pairs_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pairs_r     <= pairs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    out_pop_r    <= out_pop_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_pop_value   = out_pop_r;
  assign out_status      = out_status_r;
  assign out_entry_count = cnt_ext[CNT_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_swap_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW_RD || state_r == S_SW_WA || state_r == S_SW_WB) |-> pairs_r != '0)
    else $error("swap walk running with no pair left");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> count_r == CW'(DEPTH))
    else $error("full status reported while not full");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (count_r == '0 && out_pop_value == POP_EMPTY))
    else $error("empty status reported while entries are held");

endmodule

// ===== tb/sv/tb_fifo_with_prefix_reverse_unit.sv =====
// Self-checking testbench for fifo_with_prefix_reverse_unit: a directed pass over
// the corner cases, then random enqueue/dequeue/reverse traffic checked by a scoreboard.
// Depends on fpr_pkg and the top level of the block.
`timescale 1ns / 1ps

module tb_fifo_with_prefix_reverse_unit;
  import fpr_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int RANDOM_BEATS = 750;
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  typedef struct {
    logic signed [VAL_W-1:0] pop_value;
    logic [ST_W-1:0]         status;
    logic [CNT_W-1:0]        entry_count;
  } queue_result_t;

  // Tracks the ring contents and the expected result of every accepted beat.
  class fifo_reverse_scoreboard;
    logic [VAL_W-1:0] ring [QUEUE_DEPTH];
    logic [5:0]       head;
    logic [5:0]       tail;
    logic [CNT_W-1:0] held;
    queue_result_t    expected_results[$];
    int               mismatch_count;

    function new();
      head = '0;
      tail = '0;
      held = '0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report_mismatch(input string msg);
      $display("tb_fifo_with_prefix_reverse_unit: mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
    endtask

    function void note_operation(input logic [OP_W-1:0] op,
                                 input logic signed [VAL_W-1:0] value,
                                 input logic [CNT_W-1:0] k);
      queue_result_t    res;
      logic [VAL_W-1:0] swap_word;
      logic [5:0]       lo_idx;
      logic [5:0]       hi_idx;
      int               lo;
      int               hi;
      res.pop_value = POP_NONE;
      res.status = ST_OK;
      case (op)
        OP_ENQ: begin
          if (held >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            ring[tail] = value;
            tail = tail + 6'd1;
            held = held + 7'd1;
          end
        end
        OP_DEQ: begin
          if (held == 0) begin
            res.pop_value = POP_EMPTY;
            res.status = ST_EMPTY;
          end else begin
            res.pop_value = ring[head];
            head = head + 6'd1;
            held = held - 7'd1;
          end
        end
        OP_REV: begin
          if (k == 0 || k > held) begin
            res.status = ST_BADK;
          end else begin
            // Swap pairwise from both ends of the k oldest entries.
            lo = 0;
            hi = int'(k) - 1;
            while (lo < hi) begin
              lo_idx = head + 6'(lo);
              hi_idx = head + 6'(hi);
              swap_word = ring[lo_idx];
              ring[lo_idx] = ring[hi_idx];
              ring[hi_idx] = swap_word;
              lo++;
              hi--;
            end
          end
        end
        default: begin
        end
      endcase
      res.entry_count = held;
      expected_results.push_back(res);
    endfunction

    task check_result(input logic signed [VAL_W-1:0] pop_value,
                      input logic [ST_W-1:0] status,
                      input logic [CNT_W-1:0] entry_count);
      queue_result_t exp_res;
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        exp_res = expected_results.pop_front();
        if (pop_value !== exp_res.pop_value)
          report_mismatch($sformatf("pop_value %0d, expected %0d",
                                    pop_value, exp_res.pop_value));
        if (status !== exp_res.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_res.status));
        if (entry_count !== exp_res.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    entry_count, exp_res.entry_count));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [OP_W-1:0]         in_operation;
  logic signed [VAL_W-1:0] in_push_value;
  logic [CNT_W-1:0]        in_reverse_count;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_pop_value;
  logic [ST_W-1:0]         out_status;
  logic [CNT_W-1:0]        out_entry_count;

  fifo_reverse_scoreboard sb = new();

  int fill_level;
  int beats_sent;
  int burst_left;

  fifo_with_prefix_reverse_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_push_value    (in_push_value),
    .in_reverse_count (in_reverse_count),
    .out_valid        (out_valid),
    .out_pop_value    (out_pop_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Beats are noted and results checked on the values present before each edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_pop_value, out_status, out_entry_count);
      if (start && !busy)
        sb.note_operation(in_operation, in_push_value, in_reverse_count);
    end
  end

  // Called at a rising edge; returns at the edge that takes the beat.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] value,
                           input logic [CNT_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start <= 1'b1;
    in_operation <= op;
    in_push_value <= value;
    in_reverse_count <= k;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (op == OP_ENQ && fill_level < QUEUE_DEPTH)
      fill_level++;
    else if (op == OP_DEQ && fill_level > 0)
      fill_level--;
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_bad_count();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return (fill_level < 127) ? CNT_W'(fill_level + 1) : 7'd0;
      default: return (fill_level < 127) ? CNT_W'($urandom_range(fill_level + 1, 127)) : 7'd0;
    endcase
  endfunction

  task automatic fill_queue();
    int extra;
    while (fill_level < QUEUE_DEPTH)
      send_beat(OP_ENQ, pick_word(), CNT_W'($urandom));
    extra = $urandom_range(1, 2);
    repeat (extra) send_beat(OP_ENQ, pick_word(), '0);
    send_beat(OP_REV, '0, CNT_W'(QUEUE_DEPTH));
    send_beat(OP_REV, '0, CNT_W'($urandom_range(1, QUEUE_DEPTH)));
  endtask

  task automatic drain_queue();
    int extra;
    while (fill_level > 0)
      send_beat(OP_DEQ, pick_word(), CNT_W'($urandom));
    extra = $urandom_range(1, 2);
    repeat (extra) send_beat(OP_DEQ, pick_word(), CNT_W'($urandom));
  endtask

  task automatic mixed_traffic(input int beats);
    int roll;
    repeat (beats) begin
      roll = $urandom_range(0, 99);
      if (roll < 40)
        send_beat(OP_ENQ, pick_word(), CNT_W'($urandom));
      else if (roll < 70)
        send_beat(OP_DEQ, pick_word(), CNT_W'($urandom));
      else if (roll < 95) begin
        if (fill_level > 0 && $urandom_range(0, 4) != 0)
          send_beat(OP_REV, pick_word(), CNT_W'($urandom_range(1, fill_level)));
        else
          send_beat(OP_REV, pick_word(), pick_bad_count());
      end else
        send_beat(OP_IGNORED, pick_word(), CNT_W'($urandom));
    end
  endtask

  initial begin
    int episode;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_operation <= OP_ENQ;
    in_push_value <= '0;
    in_reverse_count <= '0;
    fill_level = 0;
    beats_sent = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty queue: dequeue underflow, both kinds of bad reverse count, unused code.
    send_beat(OP_DEQ, 32'sd5, 7'd0);
    send_beat(OP_REV, '0, 7'd0);
    send_beat(OP_REV, '0, 7'd1);
    send_beat(OP_IGNORED, '0, '0);
    send_beat(OP_ENQ, 32'sh7FFF_FFFF, 7'd127);
    send_beat(OP_ENQ, 32'sh8000_0000, '0);
    send_beat(OP_ENQ, -32'sd1, '0);
    send_beat(OP_ENQ, 32'sd0, '0);
    send_beat(OP_ENQ, 32'sd1, '0);
    send_beat(OP_ENQ, 32'sh25A5_5A5A, '0);
    send_beat(OP_REV, '0, 7'd6);
    send_beat(OP_REV, '0, 7'd7);
    send_beat(OP_REV, -32'sd1, 7'd127);
    send_beat(OP_REV, '0, 7'd1);
    send_beat(OP_REV, '0, 7'd5);
    send_beat(OP_IGNORED, -32'sd1, 7'd127);
    repeat (6) send_beat(OP_DEQ, '0, '0);
    send_beat(OP_DEQ, '0, '0);
    wait_drained();

    episode = 0;
    while (beats_sent < RANDOM_BEATS + 23) begin
      if (episode == 0)
        fill_queue();
      else if (episode == 1)
        drain_queue();
      else begin
        case ($urandom_range(0, 9))
          0: fill_queue();
          1: drain_queue();
          default: mixed_traffic($urandom_range(5, 40));
        endcase
      end
      if ($urandom_range(0, 9) == 0)
        wait_drained();
      episode++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("tb_fifo_with_prefix_reverse_unit: done, clean");
    else
      $display("tb_fifo_with_prefix_reverse_unit: done, errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_fifo_with_prefix_reverse_unit: done, errors");
    $finish;
  end

endmodule
